FILE: hw/rtl/sts_pkg.sv
// Shared types, character codes and helpers for the SQL token scanner.
`timescale 1ns / 1ps

package sts_pkg;

    // Scanner modes
    typedef enum logic [2:0] {
        MODE_IDLE        = 3'd0,
        MODE_WORD        = 3'd1,
        MODE_COMMENT     = 3'd2,
        MODE_QUOTED      = 3'd3,
        MODE_QUOTED_SEEN = 3'd4,
        MODE_STRING      = 3'd5,
        MODE_STRING_SEEN = 3'd6,
        MODE_OVERFLOW    = 3'd7
    } t_mode;

    // Token kinds as they leave the block
    typedef enum logic [3:0] {
        KIND_WORD        = 4'd0,
        KIND_QUOTED      = 4'd1,
        KIND_STRING      = 4'd2,
        KIND_MINUS       = 4'd3,
        KIND_DOT         = 4'd4,
        KIND_COMMA       = 4'd5,
        KIND_SEMI        = 4'd6,
        KIND_LPAREN      = 4'd7,
        KIND_RPAREN      = 4'd8,
        KIND_END         = 4'd9,
        KIND_UNCL_QUOTED = 4'd10,
        KIND_UNCL_STRING = 4'd11,
        KIND_OVERFLOW    = 4'd12
    } t_kind;

    // Character codes
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DEL    = 8'h7F;

    localparam logic [15:0] SAT_MAX16 = 16'hFFFF;

    // Up to three results per byte travel together as one bundle
    localparam int TOK_SLOTS   = 3;
    localparam int SLOT_W      = $clog2(TOK_SLOTS);
    localparam int CNT_W       = $clog2(TOK_SLOTS + 1);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        t_kind       kind;
        logic [15:0] start;
        logic [15:0] length;
        logic        last;
    } t_token;

    typedef struct packed {
        logic [CNT_W-1:0]           count;
        t_token [TOK_SLOTS-1:0]     tok;
    } t_bundle;

    function automatic t_token f_tok(input t_kind kind, input logic [15:0] start,
                                     input logic [15:0] length, input logic last);
        t_token t;
        t.kind   = kind;
        t.start  = start;
        t.length = length;
        t.last   = last;
        return t;
    endfunction

    function automatic logic f_is_word(input logic [7:0] b);
        return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h7A) ||
               (b >= 8'h41 && b <= 8'h5A) || (b == CH_UNDER);
    endfunction

endpackage

FILE: hw/rtl/sql_token_scanner_top.sv
// Top level of the SQL token scanner: front scanner, bundle queue, output stage.
// A result passes through the bundle queue, then the output register. The front
// takes one byte per cycle unless the queue is full; results leave one per cycle
// from the output register while i_stall is low, so a byte with several results
// holds the output stage longer; the four-bundle queue absorbs the difference.
// Reset (synchronous, active low) clears the scan state, empties the queue
// and drops any pending output beat.
`timescale 1ns / 1ps

module sql_token_scanner_top import sts_pkg::*; #(
    parameter int MAX_TEXT_BYTES = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_text_byte,
    input  logic        i_final_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_token_kind,
    output logic [15:0] o_token_start,
    output logic [15:0] o_token_length,
    output logic        o_final_result
);

    logic    q_full;
    logic    q_valid;
    logic    push;
    logic    pop;
    t_bundle push_bundle;
    t_bundle head_bundle;
    t_token  out_tok;

    sts_front #(
        .MAX_TEXT_BYTES(MAX_TEXT_BYTES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_q_full     (q_full),
        .i_text_byte  (i_text_byte),
        .i_final_byte (i_final_byte),
        .o_stall      (o_stall),
        .o_push       (push),
        .o_bundle     (push_bundle)
    );

    sts_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_bundle (push_bundle),
        .i_pop    (pop),
        .o_full   (q_full),
        .o_valid  (q_valid),
        .o_bundle (head_bundle)
    );

    sts_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_bundle  (head_bundle),
        .o_pop     (pop),
        .i_stall   (i_stall),
        .o_valid   (o_valid),
        .o_token   (out_tok)
    );

    assign o_token_kind   = out_tok.kind;
    assign o_token_start  = out_tok.start;
    assign o_token_length = out_tok.length;
    assign o_final_result = out_tok.last;

endmodule

FILE: hw/rtl/sts_front.sv
// Front part: accepts text bytes, tracks scan mode, builds result bundles.
`timescale 1ns / 1ps

module sts_front import sts_pkg::*; #(
    parameter int MAX_TEXT_BYTES = 65536
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic       i_q_full,
    input  logic [7:0] i_text_byte,
    input  logic       i_final_byte,
    output logic       o_stall,
    output logic       o_push,
    output t_bundle    o_bundle
);

    localparam int OFFS_W  = $clog2(MAX_TEXT_BYTES) + 1;
    localparam int START_W = $clog2(MAX_TEXT_BYTES);
    localparam int SAT_W   = (OFFS_W > 16) ? OFFS_W : 16;
    localparam logic [OFFS_W-1:0] OFFS_MAX = OFFS_W'(MAX_TEXT_BYTES);

    t_mode              r_mode, n_mode;
    logic [OFFS_W-1:0]  r_offset, n_offset;
    logic [START_W-1:0] r_open, n_open;
    logic               r_dash, n_dash;

    logic              accept;
    logic              ovf;
    logic              idle;
    logic              closed;
    logic [7:0]        b;
    logic [OFFS_W-1:0] pos_end;
    logic [OFFS_W-1:0] len_run;
    logic [OFFS_W-1:0] len_fin;
    logic [3:0]        c_v;
    t_token            c_tok [4];
    logic [CNT_W-1:0]  cnt;

    // Clamp an offset or length to 16 bits
    function automatic logic [15:0] f_sat(input logic [OFFS_W-1:0] v);
        logic [SAT_W-1:0] ve;
        ve = SAT_W'(v);
        if (ve > SAT_W'(SAT_MAX16)) begin
            return SAT_MAX16;
        end
        return ve[15:0];
    endfunction

    assign b       = i_text_byte;
    assign o_stall = i_q_full;
    assign accept  = i_valid && !i_q_full;
    assign ovf     = (r_mode == MODE_OVERFLOW) || (r_offset == OFFS_MAX);
    assign pos_end = r_offset + OFFS_W'(1);
    assign len_run = r_offset - OFFS_W'(r_open);

    // Next scan state: close the open token, then scan a byte between tokens
    always_comb begin
        n_mode = r_mode;
        n_dash = r_dash;
        n_open = r_open;
        idle   = 1'b0;

        if (ovf) begin
            n_mode = MODE_OVERFLOW;
            n_dash = 1'b0;
        end else begin
            if (r_dash) begin
                n_dash = 1'b0;
                if (b == CH_MINUS) begin
                    n_mode = MODE_COMMENT;
                end else begin
                    idle = 1'b1;
                end
            end else begin
                case (r_mode)
                    MODE_WORD: begin
                        if (!f_is_word(b)) begin
                            n_mode = MODE_IDLE;
                            idle   = 1'b1;
                        end
                    end
                    MODE_COMMENT: begin
                        if (b == CH_LF || b == CH_CR) begin
                            n_mode = MODE_IDLE;
                        end
                    end
                    MODE_QUOTED: begin
                        if (b == CH_DQUOTE) begin
                            n_mode = MODE_QUOTED_SEEN;
                        end
                    end
                    MODE_STRING: begin
                        if (b == CH_SQUOTE) begin
                            n_mode = MODE_STRING_SEEN;
                        end
                    end
                    MODE_QUOTED_SEEN: begin
                        if (b == CH_DQUOTE) begin
                            n_mode = MODE_QUOTED;
                        end else begin
                            n_mode = MODE_IDLE;
                            idle   = 1'b1;
                        end
                    end
                    MODE_STRING_SEEN: begin
                        if (b == CH_SQUOTE) begin
                            n_mode = MODE_STRING;
                        end else begin
                            n_mode = MODE_IDLE;
                            idle   = 1'b1;
                        end
                    end
                    default: begin
                        idle = 1'b1;
                    end
                endcase
            end

            // Open a dash, quote or word that starts between tokens
            if (idle) begin
                case (b)
                    CH_MINUS: begin
                        n_dash = 1'b1;
                        n_open = START_W'(r_offset);
                    end
                    CH_DQUOTE: begin
                        n_open = START_W'(r_offset);
                        n_mode = MODE_QUOTED;
                    end
                    CH_SQUOTE: begin
                        n_open = START_W'(r_offset);
                        n_mode = MODE_STRING;
                    end
                    default: begin
                        if (f_is_word(b)) begin
                            n_open = START_W'(r_offset);
                            n_mode = MODE_WORD;
                        end
                    end
                endcase
            end
        end
    end

    // Result candidates: closed token, one-byte token, flushed token, closing result
    always_comb begin
        closed  = 1'b1;
        len_fin = '0;
        c_v     = '0;
        for (int i = 0; i < 4; i++) begin
            c_tok[i] = '0;
        end

        // Close the open token
        if (!ovf) begin
            if (r_dash) begin
                if (b != CH_MINUS) begin
                    c_v[0]   = 1'b1;
                    c_tok[0] = f_tok(KIND_MINUS, f_sat(OFFS_W'(r_open)), 16'd1, 1'b0);
                end
            end else begin
                case (r_mode)
                    MODE_WORD: begin
                        if (!f_is_word(b)) begin
                            c_v[0]   = 1'b1;
                            c_tok[0] = f_tok(KIND_WORD, f_sat(OFFS_W'(r_open)),
                                             f_sat(len_run), 1'b0);
                        end
                    end
                    MODE_QUOTED_SEEN: begin
                        if (b != CH_DQUOTE) begin
                            c_v[0]   = 1'b1;
                            c_tok[0] = f_tok(KIND_QUOTED, f_sat(OFFS_W'(r_open)),
                                             f_sat(len_run), 1'b0);
                        end
                    end
                    MODE_STRING_SEEN: begin
                        if (b != CH_SQUOTE) begin
                            c_v[0]   = 1'b1;
                            c_tok[0] = f_tok(KIND_STRING, f_sat(OFFS_W'(r_open)),
                                             f_sat(len_run), 1'b0);
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end

        // Emit punctuation and stray bytes that fall between tokens
        if (idle) begin
            case (b)
                CH_MINUS, CH_DQUOTE, CH_SQUOTE: begin
                    // opened by the next-state logic
                end
                CH_DOT: begin
                    c_v[1]   = 1'b1;
                    c_tok[1] = f_tok(KIND_DOT, f_sat(r_offset), 16'd1, 1'b0);
                end
                CH_COMMA: begin
                    c_v[1]   = 1'b1;
                    c_tok[1] = f_tok(KIND_COMMA, f_sat(r_offset), 16'd1, 1'b0);
                end
                CH_SEMI: begin
                    c_v[1]   = 1'b1;
                    c_tok[1] = f_tok(KIND_SEMI, f_sat(r_offset), 16'd1, 1'b0);
                end
                CH_LPAREN: begin
                    c_v[1]   = 1'b1;
                    c_tok[1] = f_tok(KIND_LPAREN, f_sat(r_offset), 16'd1, 1'b0);
                end
                CH_RPAREN: begin
                    c_v[1]   = 1'b1;
                    c_tok[1] = f_tok(KIND_RPAREN, f_sat(r_offset), 16'd1, 1'b0);
                end
                default: begin
                    // skip control and space bytes; a stray byte is a one-byte word
                    if (b > CH_SPACE && b != CH_DEL && !f_is_word(b)) begin
                        c_v[1]   = 1'b1;
                        c_tok[1] = f_tok(KIND_WORD, f_sat(r_offset), 16'd1, 1'b0);
                    end
                end
            endcase
        end

        // Close the text on its last byte
        if (i_final_byte) begin
            len_fin = pos_end - OFFS_W'(n_open);
            if (n_mode == MODE_OVERFLOW) begin
                c_v[3]   = 1'b1;
                c_tok[3] = f_tok(KIND_OVERFLOW, 16'd0, 16'd0, 1'b1);
            end else begin
                if (n_dash) begin
                    c_v[2]   = 1'b1;
                    c_tok[2] = f_tok(KIND_MINUS, f_sat(OFFS_W'(n_open)), 16'd1, 1'b0);
                end else if (n_mode == MODE_WORD) begin
                    c_v[2]   = 1'b1;
                    c_tok[2] = f_tok(KIND_WORD, f_sat(OFFS_W'(n_open)),
                                     f_sat(len_fin), 1'b0);
                end else if (n_mode == MODE_QUOTED_SEEN) begin
                    c_v[2]   = 1'b1;
                    c_tok[2] = f_tok(KIND_QUOTED, f_sat(OFFS_W'(n_open)),
                                     f_sat(len_fin), 1'b0);
                end else if (n_mode == MODE_STRING_SEEN) begin
                    c_v[2]   = 1'b1;
                    c_tok[2] = f_tok(KIND_STRING, f_sat(OFFS_W'(n_open)),
                                     f_sat(len_fin), 1'b0);
                end else if (n_mode == MODE_QUOTED) begin
                    c_v[2]   = 1'b1;
                    c_tok[2] = f_tok(KIND_UNCL_QUOTED, f_sat(OFFS_W'(n_open)),
                                     f_sat(len_fin), 1'b1);
                    closed   = 1'b0;
                end else if (n_mode == MODE_STRING) begin
                    c_v[2]   = 1'b1;
                    c_tok[2] = f_tok(KIND_UNCL_STRING, f_sat(OFFS_W'(n_open)),
                                     f_sat(len_fin), 1'b1);
                    closed   = 1'b0;
                end
                if (closed) begin
                    c_v[3]   = 1'b1;
                    c_tok[3] = f_tok(KIND_END, f_sat(pos_end), 16'd0, 1'b1);
                end
            end
        end
    end

    // Pack candidates into the bundle in order, keeping at most three
    always_comb begin
        cnt      = '0;
        o_bundle = '0;
        for (int i = 0; i < 4; i++) begin
            if (c_v[i] && cnt != CNT_W'(TOK_SLOTS)) begin
                o_bundle.tok[SLOT_W'(cnt)] = c_tok[i];
                cnt = cnt + CNT_W'(1);
            end
        end
        o_bundle.count = cnt;
    end

    assign o_push = accept && (cnt != '0);

    // Advance the offset, saturating at the maximum text length
    assign n_offset = (r_offset < OFFS_MAX) ? pos_end : r_offset;

    // Update scan state on each accepted beat; reset after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_offset <= '0;
            r_open   <= '0;
            r_dash   <= 1'b0;
        end else if (accept) begin
            if (i_final_byte) begin
                r_mode   <= MODE_IDLE;
                r_offset <= '0;
                r_open   <= '0;
                r_dash   <= 1'b0;
            end else begin
                r_mode   <= n_mode;
                r_offset <= n_offset;
                r_open   <= n_open;
                r_dash   <= n_dash;
            end
        end
    end

endmodule

FILE: hw/rtl/sts_queue.sv
// Short queue of result bundles between the front and back parts.
`timescale 1ns / 1ps

module sts_queue import sts_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_bundle i_bundle,
    input  logic    i_pop,
    output logic    o_full,
    output logic    o_valid,
    output t_bundle o_bundle
);

    t_bundle           r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full   = (r_count == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign o_valid  = (r_count != '0);
    assign o_bundle = r_mem[r_rd_ptr];
    assign do_push  = i_push && !o_full;
    assign do_pop   = i_pop && o_valid;

    // Store pushed bundles
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_bundle;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + (QPTR_W + 1)'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - (QPTR_W + 1)'(1);
            end
        end
    end

endmodule

FILE: hw/rtl/sts_back.sv
// Back part: walks each bundle and delivers one result beat at a time.
`timescale 1ns / 1ps

module sts_back import sts_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_valid,
    input  t_bundle i_bundle,
    output logic    o_pop,
    input  logic    i_stall,
    output logic    o_valid,
    output t_token  o_token
);

    logic [SLOT_W-1:0] r_idx;
    logic              r_valid;
    t_token            r_tok;
    logic              load;
    logic              take;
    logic              last_slot;

    assign load      = !r_valid || !i_stall;
    assign take      = load && i_q_valid;
    assign last_slot = (CNT_W'(r_idx) + CNT_W'(1)) == i_bundle.count;
    assign o_pop     = take && last_slot;
    assign o_valid   = r_valid;
    assign o_token   = r_tok;

    // Hold the output register until taken; refill from the head bundle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (load) begin
            r_valid <= i_q_valid;
            if (take) begin
                r_idx <= last_slot ? '0 : r_idx + SLOT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_tok <= i_bundle.tok[r_idx];
        end
    end

endmodule
